>>> hw/rtl/bff_pkg.sv
// Package for the FNV-1a Bloom filter unit: widths, constants, codes, helpers.
// Used by bloom_filter_fnv1a_unit. No dependencies.
package bff_pkg;
  localparam int unsigned NumBitsDefault   = 65536;
  localparam int unsigned MaxHashesDefault = 4;
  localparam int unsigned SeedRegs  = 4;
  localparam int unsigned WordBits  = 64;
  localparam logic [63:0] FnvBasis  = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime  = 64'h00000100000001B3;

  typedef enum logic [1:0] {
    FuncAdd   = 2'd0,
    FuncQuery = 2'd1,
    FuncClear = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RegFilterBits = 3'd0,
    RegHashCount  = 3'd1,
    RegSeed0      = 3'd2,
    RegSeed1      = 3'd3,
    RegSeed2      = 3'd4,
    RegSeed3      = 3'd5,
    RegNone6      = 3'd6,
    RegNone7      = 3'd7
  } reg_e;

  // Hash times the FNV prime: prime = 2^40 + 0x1B3, so only a 64x9 product.
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    logic [63:0] lo;
    lo = h * 64'h1B3;
    return lo + {h[23:0], 40'd0};
  endfunction
endpackage

>>> hw/rtl/bff_mod.sv
// Iterative 64-bit by 17-bit remainder unit, restoring, one bit a cycle.
// Has no dependency on bff_pkg; started with a pulse.
module bff_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [16:0] divisor_i,
  output logic        done_o,
  output logic [16:0] rem_o
);
  logic [63:0] shf_q, shf_d;
  logic [17:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [17:0] trial;

  // one quotient bit per cycle
  always_comb begin
    shf_d = shf_q; rem_d = rem_q; cnt_d = cnt_q; run_d = run_q;
    trial = {rem_q[16:0], shf_q[63]};
    if (start_i) begin
      shf_d = dividend_i; rem_d = '0; cnt_d = 7'd64; run_d = 1'b1;
    end else if (run_q) begin
      shf_d = {shf_q[62:0], 1'b0};
      rem_d = (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    shf_q <= shf_d; rem_q <= rem_d;
  end

  assign done_o = run_q && (cnt_q == 7'd1);
  assign rem_o  = rem_d[16:0];
endmodule

>>> hw/rtl/bloom_filter_fnv1a_unit.sv
// Bloom filter unit, seeded FNV-1a hashes, one key byte per transaction (bff_pkg, bff_mod).
// Non-last byte: taken without leaving StIdle, busy stays low. Last byte: per hash a remainder
// (StMod), then a read-modify-write of the store (StRd, StWr); then StDone and the strobe.
// Clear: strobe the next cycle, then busy for a sweep of ceil(NUM_BITS/64) words.
// Reset runs the same sweep before the first transaction is taken.
// Results show for one cycle on done_o; the receiver cannot stall.
module bloom_filter_fnv1a_unit #(
  parameter int unsigned NUM_BITS   = bff_pkg::NumBitsDefault,
  parameter int unsigned MAX_HASHES = bff_pkg::MaxHashesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [7:0]  key_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        done_o,
  output logic [1:0]  done_kind_o,
  output logic        present_o,
  output logic [31:0] item_count_o
);
  localparam int unsigned Words = (NUM_BITS + bff_pkg::WordBits - 1) / bff_pkg::WordBits;
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned KMax  = (MAX_HASHES < bff_pkg::SeedRegs) ? MAX_HASHES
                                                                    : bff_pkg::SeedRegs;
  localparam logic [16:0] SizeMax = (NUM_BITS > 65536) ? 17'd65536 : 17'(NUM_BITS);

  typedef enum logic [5:0] {
    StClr  = 6'b000001,
    StIdle = 6'b000010,
    StMod  = 6'b000100,
    StRd   = 6'b001000,
    StWr   = 6'b010000,
    StDone = 6'b100000
  } state_e;

  state_e      st_q, st_d;
  logic [16:0] fbits_q;
  logic [2:0]  hcnt_q;
  logic [63:0] seed_q [bff_pkg::SeedRegs];
  logic [63:0] hash_q [bff_pkg::SeedRegs];
  logic        in_key_q;
  logic [31:0] count_q;
  logic [1:0]  hi_q;
  logic [2:0]  k_q;
  logic [16:0] m_q;
  logic        add_q, all_q;
  logic [16:0] idx_q;
  logic [AW-1:0] clr_q;
  logic [63:0] mem [Words];
  logic [63:0] rd_q;
  logic        mod_go, mod_done;
  logic        mod_go_q;
  logic [16:0] mod_rem;
  logic        acc;
  logic [2:0]  k_eff;
  logic [16:0] m_eff;
  logic [AW-1:0] widx;

  assign busy        = (st_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign acc         = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbits_q <= 17'd65536; hcnt_q <= 3'd3;
      for (int i = 0; i < bff_pkg::SeedRegs; i++) seed_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (bff_pkg::reg_e'(cfg_index_i))
        bff_pkg::RegFilterBits: fbits_q <= cfg_data_i[16:0];
        bff_pkg::RegHashCount:  hcnt_q  <= cfg_data_i[2:0];
        bff_pkg::RegSeed0:      seed_q[0] <= cfg_data_i;
        bff_pkg::RegSeed1:      seed_q[1] <= cfg_data_i;
        bff_pkg::RegSeed2:      seed_q[2] <= cfg_data_i;
        bff_pkg::RegSeed3:      seed_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    k_eff = (32'(hcnt_q) > KMax) ? 3'(KMax) : hcnt_q;
    m_eff = (fbits_q == '0) ? 17'd1 : ((fbits_q > SizeMax) ? SizeMax : fbits_q);
  end

  // remainder starts in the first StMod cycle, once hash_q and hi_q are settled
  bff_mod u_mod (
    .clk_i, .rst_ni,
    .start_i(mod_go_q), .dividend_i(hash_q[hi_q]), .divisor_i(m_q),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  assign widx = AW'(idx_q >> 6);

  // sequencer
  always_comb begin
    st_d   = st_q;
    mod_go = 1'b0;
    unique case (st_q)
      StClr:  if (32'(clr_q) == Words - 1) st_d = StIdle;
      StIdle: begin
        if (acc) begin
          if (func_i == bff_pkg::FuncClear) st_d = StClr;
          else if (func_i != bff_pkg::FuncNone && last_i) begin
            if (k_eff == '0) st_d = StDone;
            else begin st_d = StMod; end
          end
        end
      end
      StMod:  if (mod_done) st_d = StRd;
      StRd:   st_d = StWr;
      StWr:   st_d = ({1'b0, hi_q} + 3'd1 == k_q) ? StDone : StMod;
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
    if ((st_q == StIdle && st_d == StMod) || (st_q == StWr && st_d == StMod)) mod_go = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0; in_key_q <= 1'b0; count_q <= '0; hi_q <= '0;
      done_o <= 1'b0; mod_go_q <= 1'b0;
      done_kind_o <= bff_pkg::FuncAdd; present_o <= 1'b0; item_count_o <= '0;
    end else begin
      st_q     <= st_d;
      mod_go_q <= mod_go;
      done_o   <= (acc && func_i == bff_pkg::FuncClear) || (st_q == StDone);
      if (st_q == StClr) clr_q <= (32'(clr_q) == Words - 1) ? '0 : clr_q + AW'(1);
      if (acc && func_i == bff_pkg::FuncClear) begin
        in_key_q <= 1'b0; count_q <= '0;
        done_kind_o <= bff_pkg::FuncClear; present_o <= 1'b0;
        item_count_o <= '0;
      end else if (acc && func_i != bff_pkg::FuncNone) begin
        in_key_q <= !last_i;
        hi_q <= '0;
      end
      if (st_q == StWr) hi_q <= hi_q + 2'd1;
      if (st_q == StDone) begin
        done_kind_o  <= add_q ? bff_pkg::FuncAdd : bff_pkg::FuncQuery;
        present_o    <= add_q ? 1'b0 : all_q;
        item_count_o <= (add_q && count_q != '1) ? count_q + 32'd1 : count_q;
        if (add_q && count_q != '1) count_q <= count_q + 32'd1;
      end
    end
  end

  // hash update and per-key sampling
  always_ff @(posedge clk_i) begin
    if (acc && func_i != bff_pkg::FuncClear && func_i != bff_pkg::FuncNone) begin
      for (int i = 0; i < bff_pkg::SeedRegs; i++) begin
        logic [63:0] h;
        h = in_key_q ? hash_q[i] : (bff_pkg::FnvBasis ^ seed_q[i]);
        if (byte_valid_i) h = bff_pkg::fnv_mul(h ^ {56'd0, key_byte_i});
        hash_q[i] <= h;
      end
      k_q <= k_eff; m_q <= m_eff;
      add_q <= (func_i == bff_pkg::FuncAdd); all_q <= 1'b1;
    end
    if (mod_done) idx_q <= mod_rem;
    if (st_q == StWr && !add_q && !rd_q[idx_q[5:0]]) all_q <= 1'b0;
  end

  // bit store: clear sweep, or read one word and, for an add, set the bit and write it back
  always_ff @(posedge clk_i) begin
    if (st_q == StClr) mem[clr_q] <= '0;
    else if (st_q == StWr && add_q) mem[widx] <= rd_q | (64'd1 << idx_q[5:0]);
    if (st_q == StRd) rd_q <= mem[widx];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) (st_q == StDone) |=> done_o)
    else $error("no result strobe after a finished key");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (st_q == StWr) |-> busy)
    else $error("store write while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) mod_done |-> (st_q == StMod))
    else $error("remainder finished outside its phase");
endmodule
